>>> hdl/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// dhfk_pkg
// shared types, fixed-point constants and joint tables for the six-joint
// dh forward kinematics pipeline
// ----------------------------------------------------------------------------
package dhfk_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int TRIG_ITERATIONS = 16;
  localparam int NUM_JOINTS      = 6;

  localparam int ANG_W   = 17;
  localparam int OUT_W   = 18;
  localparam int OUT_FRAC = 16;
  localparam int ENT_W   = FRAC_BITS + 4;
  localparam int PROD_W  = 2 * ENT_W;
  localparam int SUM_W   = PROD_W + 2;

  localparam int RED_W   = ANG_W + 1;
  localparam int MAG_W   = 14;
  localparam int CX_W    = 34;
  localparam int CZ_W    = 33;
  localparam int TRIG_SH = 30 - FRAC_BITS;

  localparam int TURN    = 36000;
  localparam int HALF    = 18000;
  localparam int QUARTER = 9000;

  localparam longint PI_Q30   = 64'd3373259426;
  localparam longint GAIN_Q30 = 64'd652032874;
  localparam longint PI_QUO   = PI_Q30 / HALF;
  localparam longint PI_REM   = PI_Q30 % HALF;
  localparam int     P1_W     = 32;
  localparam int     P2_W     = 26;
  localparam int     Q_W      = 12;
  localparam int     RECIP_SH = P2_W + 15;
  localparam longint RECIP    = ((64'd1 << RECIP_SH) + HALF - 1) / HALF;
  localparam int     RECIP_W  = 27;

  localparam int LANE_LAT  = 6 + TRIG_ITERATIONS;
  localparam int CHAIN_LAT = 2 * (NUM_JOINTS - 1);
  localparam int PIPE_LAT  = LANE_LAT + CHAIN_LAT;
  localparam int TAP_N     = 2 * (NUM_JOINTS - 2) + 1;

  localparam longint ONE_L = 64'sd1 <<< FRAC_BITS;

  localparam longint R2 = -((64'sd425000 * ONE_L + 64'sd500000) / 64'sd1000000);
  localparam longint R3 = -((64'sd392200 * ONE_L + 64'sd500000) / 64'sd1000000);
  localparam longint D1 = (64'sd162500 * ONE_L + 64'sd500000) / 64'sd1000000;
  localparam longint D4 = (64'sd133300 * ONE_L + 64'sd500000) / 64'sd1000000;
  localparam longint D5 = (64'sd99700 * ONE_L + 64'sd500000) / 64'sd1000000;
  localparam longint D6 = (64'sd99600 * ONE_L + 64'sd500000) / 64'sd1000000;

  typedef logic signed [ENT_W-1:0]  ent_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    ent_t s;
    ent_t c;
    ent_t rc;
    ent_t rs;
  } joint_t;

  typedef struct packed {
    ent_t x;
    ent_t y;
    ent_t z;
  } pos_t;

  function automatic logic signed [CZ_W-1:0] atan_q30(input int i);
    logic signed [CZ_W-1:0] v;
    case (i)
      0:       v = 33'sd843314856;
      1:       v = 33'sd497837829;
      2:       v = 33'sd263043836;
      3:       v = 33'sd133525158;
      4:       v = 33'sd67021686;
      5:       v = 33'sd33543515;
      6:       v = 33'sd16775850;
      7:       v = 33'sd8388437;
      8:       v = 33'sd4194282;
      9:       v = 33'sd2097149;
      10:      v = 33'sd1048575;
      11:      v = 33'sd524287;
      12:      v = 33'sd262143;
      13:      v = 33'sd131071;
      14:      v = 33'sd65535;
      15:      v = 33'sd32767;
      16:      v = 33'sd16383;
      17:      v = 33'sd8191;
      18:      v = 33'sd4095;
      19:      v = 33'sd2047;
      20:      v = 33'sd1023;
      21:      v = 33'sd511;
      22:      v = 33'sd255;
      23:      v = 33'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic ent_t joint_r(input int j);
    ent_t v;
    case (j)
      1:       v = ent_t'(R2);
      2:       v = ent_t'(R3);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic ent_t joint_d(input int j);
    ent_t v;
    case (j)
      0:       v = ent_t'(D1);
      3:       v = ent_t'(D4);
      4:       v = ent_t'(D5);
      5:       v = ent_t'(D6);
      default: v = '0;
    endcase
    return v;
  endfunction

  // cos and sin of alpha as -1, 0 or 1
  function automatic int joint_ca(input int j);
    return (j == 1 || j == 2 || j == 5) ? 1 : 0;
  endfunction

  function automatic int joint_sa(input int j);
    int v;
    case (j)
      0, 3:    v = 1;
      4:       v = -1;
      default: v = 0;
    endcase
    return v;
  endfunction

  function automatic ent_t scale_unit(input ent_t v, input int k);
    ent_t r;
    if (k == 1) r = v;
    else if (k == -1) r = -v;
    else r = '0;
    return r;
  endfunction

  // entry of the joint transform, rows 0..3
  function automatic ent_t h_entry(input joint_t jv, input int j, input int row,
                                   input int col);
    ent_t v;
    ent_t one;
    one = ent_t'(ONE_L);
    v = '0;
    case (row)
      0: begin
        case (col)
          0:       v = jv.c;
          1:       v = -scale_unit(jv.s, joint_ca(j));
          2:       v = scale_unit(jv.s, joint_sa(j));
          default: v = jv.rc;
        endcase
      end
      1: begin
        case (col)
          0:       v = jv.s;
          1:       v = scale_unit(jv.c, joint_ca(j));
          2:       v = -scale_unit(jv.c, joint_sa(j));
          default: v = jv.rs;
        endcase
      end
      2: begin
        case (col)
          0:       v = '0;
          1:       v = scale_unit(one, joint_sa(j));
          2:       v = scale_unit(one, joint_ca(j));
          default: v = joint_d(j);
        endcase
      end
      default: v = (col == 3) ? one : '0;
    endcase
    return v;
  endfunction

  localparam int OSH_R = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int OSH_L = (FRAC_BITS > OUT_FRAC) ? 0 : OUT_FRAC - FRAC_BITS;
  localparam int OW_W  = ENT_W + OSH_L + 1;

  function automatic logic signed [OUT_W-1:0] to_out(input ent_t v);
    logic signed [OW_W-1:0] w;
    logic signed [OW_W-1:0] rnd;
    rnd = (OSH_R > 0) ? (OW_W'(1) <<< (OSH_R - 1)) : '0;
    w = (OW_W'(v) + rnd) >>> OSH_R;
    w = w <<< OSH_L;
    if (w > OW_W'((1 << (OUT_W - 1)) - 1)) return {1'b0, {(OUT_W-1){1'b1}}};
    if (w < -OW_W'(1 << (OUT_W - 1)))      return {1'b1, {(OUT_W-1){1'b0}}};
    return w[OUT_W-1:0];
  endfunction

endpackage

>>> hdl/dhfk_lane.sv
// ----------------------------------------------------------------------------
// dhfk_lane
// per-joint lane: angle reduction, radian scaling, pipelined cordic and
// the translation terms r*cos, r*sin of one dh transform
// ----------------------------------------------------------------------------
module dhfk_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [dhfk_pkg::ANG_W-1:0] angle,
  input  dhfk_pkg::ent_t                    r_coef,
  output dhfk_pkg::joint_t                  joint
);

  localparam int IT = dhfk_pkg::TRIG_ITERATIONS;

  logic signed [dhfk_pkg::RED_W-1:0] m0, m1, m2, m3;
  logic                              mir;

  logic [dhfk_pkg::MAG_W-1:0] a_mag;
  logic                       a_neg, a_negc;
  logic [dhfk_pkg::P1_W-1:0]  b_p1;
  logic [dhfk_pkg::P2_W-1:0]  b_p2;
  logic                       b_neg, b_negc;
  logic [dhfk_pkg::P1_W-1:0]  c_p1;
  logic [dhfk_pkg::Q_W-1:0]   c_q;
  logic                       c_neg, c_negc;
  logic [dhfk_pkg::P2_W+dhfk_pkg::RECIP_W-1:0] recip_prod;
  logic [dhfk_pkg::P1_W-1:0]  zmag;
  logic signed [dhfk_pkg::CZ_W-1:0] z_d;
  logic                       d_negc;

  logic signed [dhfk_pkg::CX_W-1:0] cx [0:IT];
  logic signed [dhfk_pkg::CX_W-1:0] cy [0:IT];
  logic signed [dhfk_pkg::CZ_W-1:0] cz [0:IT];
  logic                             nc [0:IT];

  logic signed [dhfk_pkg::CX_W-1:0] x_rnd, y_rnd;
  dhfk_pkg::ent_t                   e_s, e_c;
  logic signed [dhfk_pkg::PROD_W-1:0] rc_full, rs_full;

  // reduce into one quarter turn
  always_comb begin
    m0 = dhfk_pkg::RED_W'(angle);
    if (m0 >= dhfk_pkg::RED_W'(dhfk_pkg::TURN)) m1 = m0 - dhfk_pkg::RED_W'(dhfk_pkg::TURN);
    else if (m0 <= -dhfk_pkg::RED_W'(dhfk_pkg::TURN)) m1 = m0 + dhfk_pkg::RED_W'(dhfk_pkg::TURN);
    else m1 = m0;
    if (m1 > dhfk_pkg::RED_W'(dhfk_pkg::HALF)) m2 = m1 - dhfk_pkg::RED_W'(dhfk_pkg::TURN);
    else if (m1 < -dhfk_pkg::RED_W'(dhfk_pkg::HALF)) m2 = m1 + dhfk_pkg::RED_W'(dhfk_pkg::TURN);
    else m2 = m1;
    mir = 1'b1;
    if (m2 > dhfk_pkg::RED_W'(dhfk_pkg::QUARTER)) m3 = dhfk_pkg::RED_W'(dhfk_pkg::HALF) - m2;
    else if (m2 < -dhfk_pkg::RED_W'(dhfk_pkg::QUARTER)) begin
      m3 = -dhfk_pkg::RED_W'(dhfk_pkg::HALF) - m2;
    end else begin
      m3 = m2;
      mir = 1'b0;
    end
  end

  assign recip_prod = dhfk_pkg::P2_W'(b_p2) * dhfk_pkg::RECIP_W'(dhfk_pkg::RECIP);
  assign zmag = c_p1 + dhfk_pkg::P1_W'(c_q);

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag  <= m3[dhfk_pkg::RED_W-1] ? dhfk_pkg::MAG_W'(-m3) : dhfk_pkg::MAG_W'(m3);
      a_neg  <= m3[dhfk_pkg::RED_W-1];
      a_negc <= mir;
      b_p1   <= dhfk_pkg::P1_W'(a_mag) * dhfk_pkg::P1_W'(dhfk_pkg::PI_QUO);
      b_p2   <= dhfk_pkg::P2_W'(a_mag) * dhfk_pkg::P2_W'(dhfk_pkg::PI_REM)
                + dhfk_pkg::P2_W'(dhfk_pkg::QUARTER);
      b_neg  <= a_neg;
      b_negc <= a_negc;
      c_p1   <= b_p1;
      c_q    <= recip_prod[dhfk_pkg::RECIP_SH +: dhfk_pkg::Q_W];
      c_neg  <= b_neg;
      c_negc <= b_negc;
      z_d    <= c_neg ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
      d_negc <= c_negc;
    end
  end

  assign cx[0] = dhfk_pkg::CX_W'(dhfk_pkg::GAIN_Q30);
  assign cy[0] = '0;
  assign cz[0] = z_d;
  assign nc[0] = d_negc;

  for (genvar i = 0; i < IT; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz[i][dhfk_pkg::CZ_W-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - dhfk_pkg::atan_q30(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + dhfk_pkg::atan_q30(i);
        end
        nc[i+1] <= nc[i];
      end
    end
  end

  assign x_rnd = (cx[IT] + (dhfk_pkg::CX_W'(1) <<< (dhfk_pkg::TRIG_SH - 1))) >>> dhfk_pkg::TRIG_SH;
  assign y_rnd = (cy[IT] + (dhfk_pkg::CX_W'(1) <<< (dhfk_pkg::TRIG_SH - 1))) >>> dhfk_pkg::TRIG_SH;
  assign rc_full = (r_coef * e_c + (dhfk_pkg::PROD_W'(1) <<< (dhfk_pkg::FRAC_BITS - 1)))
                   >>> dhfk_pkg::FRAC_BITS;
  assign rs_full = (r_coef * e_s + (dhfk_pkg::PROD_W'(1) <<< (dhfk_pkg::FRAC_BITS - 1)))
                   >>> dhfk_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      e_s      <= y_rnd[dhfk_pkg::ENT_W-1:0];
      e_c      <= nc[IT] ? -x_rnd[dhfk_pkg::ENT_W-1:0] : x_rnd[dhfk_pkg::ENT_W-1:0];
      joint.s  <= e_s;
      joint.c  <= e_c;
      joint.rc <= rc_full[dhfk_pkg::ENT_W-1:0];
      joint.rs <= rs_full[dhfk_pkg::ENT_W-1:0];
    end
  end

endmodule

>>> hdl/dhfk_chain.sv
// ----------------------------------------------------------------------------
// dhfk_chain
// merge stage: chains the six joint transforms by 4x4 products, one
// multiply stage and one sum-and-round stage per product
// ----------------------------------------------------------------------------
module dhfk_chain (
  input  logic             clk,
  input  logic             en,
  input  dhfk_pkg::joint_t joints [dhfk_pkg::NUM_JOINTS],
  output dhfk_pkg::pos_t   pos
);

  localparam int NJ = dhfk_pkg::NUM_JOINTS;

  dhfk_pkg::joint_t dl [NJ][dhfk_pkg::TAP_N];
  dhfk_pkg::ent_t   tm [NJ][3][4];
  dhfk_pkg::prod_t  pr [1:NJ-1][3][4][4];
  logic signed [dhfk_pkg::SUM_W-1:0] acc [1:NJ-1][3][4];

  for (genvar j = 0; j < NJ; j++) begin : g_dly
    assign dl[j][0] = joints[j];
    for (genvar t = 0; t < dhfk_pkg::TAP_N - 1; t++) begin : g_tap
      always_ff @(posedge clk) begin
        if (en) begin
          dl[j][t+1] <= dl[j][t];
        end
      end
    end
  end

  // first joint transform is the starting product
  for (genvar i = 0; i < 3; i++) begin : g_t0r
    for (genvar c = 0; c < 4; c++) begin : g_t0c
      assign tm[0][i][c] = dhfk_pkg::h_entry(dl[0][0], 0, i, c);
    end
  end

  for (genvar k = 1; k < NJ; k++) begin : g_stage
    for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar c = 0; c < 4; c++) begin : g_col
        for (genvar q = 0; q < 4; q++) begin : g_term
          always_ff @(posedge clk) begin
            if (en) begin
              pr[k][i][c][q] <= tm[k-1][i][q]
                                * dhfk_pkg::h_entry(dl[k][2*(k-1)], k, q, c);
            end
          end
        end
        assign acc[k][i][c] = dhfk_pkg::SUM_W'(pr[k][i][c][0])
                              + dhfk_pkg::SUM_W'(pr[k][i][c][1])
                              + dhfk_pkg::SUM_W'(pr[k][i][c][2])
                              + dhfk_pkg::SUM_W'(pr[k][i][c][3])
                              + (dhfk_pkg::SUM_W'(1) <<< (dhfk_pkg::FRAC_BITS - 1));
        always_ff @(posedge clk) begin
          if (en) begin
            tm[k][i][c] <= dhfk_pkg::ENT_W'(acc[k][i][c] >>> dhfk_pkg::FRAC_BITS);
          end
        end
      end
    end
  end

  assign pos.x = tm[NJ-1][0][3];
  assign pos.y = tm[NJ-1][1][3];
  assign pos.z = tm[NJ-1][2][3];

endmodule

>>> hdl/dh_forward_kinematics_6joint_unit.sv
// ----------------------------------------------------------------------------
// dh_forward_kinematics_6joint_unit
// six joint angles in, saturated end-effector position out
// ----------------------------------------------------------------------------
// path from angle transaction to pos_valid: the lanes, the product chain and
//   one output register
// throughput: one per cycle while angle_stall is low; 16-stage cordic sets depth
// reset clears the valid bits only; no clearing pass
// ----------------------------------------------------------------------------
module dh_forward_kinematics_6joint_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                angle_valid,
  output logic                                angle_stall,
  input  logic signed [dhfk_pkg::ANG_W-1:0]   angle_base,
  input  logic signed [dhfk_pkg::ANG_W-1:0]   angle_shoulder,
  input  logic signed [dhfk_pkg::ANG_W-1:0]   angle_elbow,
  input  logic signed [dhfk_pkg::ANG_W-1:0]   angle_wrist_one,
  input  logic signed [dhfk_pkg::ANG_W-1:0]   angle_wrist_two,
  input  logic signed [dhfk_pkg::ANG_W-1:0]   angle_wrist_three,
  output logic                                pos_valid,
  input  logic                                pos_stall,
  output logic signed [dhfk_pkg::OUT_W-1:0]   pos_x,
  output logic signed [dhfk_pkg::OUT_W-1:0]   pos_y,
  output logic signed [dhfk_pkg::OUT_W-1:0]   pos_z
);

  localparam int NJ = dhfk_pkg::NUM_JOINTS;
  localparam int PL = dhfk_pkg::PIPE_LAT;

  logic signed [dhfk_pkg::ANG_W-1:0] ang [NJ];
  dhfk_pkg::joint_t                  joints [NJ];
  dhfk_pkg::pos_t                    pos;
  logic [PL-1:0]                     vld;
  logic                              adv, load;

  assign ang[0] = angle_base;
  assign ang[1] = angle_shoulder;
  assign ang[2] = angle_elbow;
  assign ang[3] = angle_wrist_one;
  assign ang[4] = angle_wrist_two;
  assign ang[5] = angle_wrist_three;

  assign adv  = !vld[PL-1] || !pos_valid || !pos_stall;
  assign load = vld[PL-1] && adv;
  assign angle_stall = !adv;

  for (genvar j = 0; j < NJ; j++) begin : g_lane
    dhfk_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .angle  (ang[j]),
      .r_coef (dhfk_pkg::joint_r(j)),
      .joint  (joints[j])
    );
  end

  dhfk_chain u_chain (
    .clk    (clk),
    .en     (adv),
    .joints (joints),
    .pos    (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      pos_valid <= 1'b0;
    end else begin
      if (adv) begin
        vld <= {vld[PL-2:0], angle_valid};
      end
      if (load) begin
        pos_valid <= 1'b1;
      end else if (!pos_stall) begin
        pos_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos_x <= dhfk_pkg::to_out(pos.x);
      pos_y <= dhfk_pkg::to_out(pos.y);
      pos_z <= dhfk_pkg::to_out(pos.z);
    end
  end

  // input held back only while a finished pose waits downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    angle_stall |-> (pos_valid && pos_stall && vld[PL-1]))
    else $error("input stalled without a blocked result");

  // a new result only appears from the last pipeline stage
  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(pos_valid) |-> $past(vld[PL-1]))
    else $error("result valid without a finished transaction");

  // a frozen pipeline keeps its last item
  a_freeze_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[PL-1] && !adv) |=> vld[PL-1])
    else $error("transaction dropped from stalled pipeline");

endmodule

>>> dv/dhfk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dhfk_checker
// watches the angle and position channels, predicts each pose from the six
// joint angles in fixed point and compares every position transaction in order
// ----------------------------------------------------------------------------
module dhfk_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              angle_valid,
  input  logic                              angle_stall,
  input  logic signed [dhfk_pkg::ANG_W-1:0] angle_base,
  input  logic signed [dhfk_pkg::ANG_W-1:0] angle_shoulder,
  input  logic signed [dhfk_pkg::ANG_W-1:0] angle_elbow,
  input  logic signed [dhfk_pkg::ANG_W-1:0] angle_wrist_one,
  input  logic signed [dhfk_pkg::ANG_W-1:0] angle_wrist_two,
  input  logic signed [dhfk_pkg::ANG_W-1:0] angle_wrist_three,
  input  logic                              pos_valid,
  input  logic                              pos_stall,
  input  logic signed [dhfk_pkg::OUT_W-1:0] pos_x,
  input  logic signed [dhfk_pkg::OUT_W-1:0] pos_y,
  input  logic signed [dhfk_pkg::OUT_W-1:0] pos_z,
  output int                                errors,
  output int                                pending,
  output int                                checked
);

  typedef struct {
    logic signed [dhfk_pkg::OUT_W-1:0] x;
    logic signed [dhfk_pkg::OUT_W-1:0] y;
    logic signed [dhfk_pkg::OUT_W-1:0] z;
  } pose_t;

  pose_t expected_poses[$];

  localparam longint ATAN_TBL[16] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767};
  localparam longint LINK_R_UM[6] = '{0, -425000, -392200, 0, 0, 0};
  localparam longint LINK_D_UM[6] = '{162500, 0, 0, 133300, 99700, 99600};
  localparam longint LINK_CA[6]   = '{0, 1, 1, 0, 0, 1};
  localparam longint LINK_SA[6]   = '{1, 0, 0, 1, -1, 0};

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint div_near(input longint n, input longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clamp_out(input longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint a, x, y, z, nx;
    bit flip;
    a = ang % 36000;
    flip = 0;
    if (a > 18000) a -= 36000;
    if (a < -18000) a += 36000;
    if (a > 9000) begin
      a = 18000 - a;
      flip = 1;
    end else if (a < -9000) begin
      a = -18000 - a;
      flip = 1;
    end
    z = div_near(a * 64'sd3373259426, 18000);
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < dhfk_pkg::TRIG_ITERATIONS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TBL[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TBL[i];
      end
      x = nx;
    end
    s = rnd_shift(y, 30 - dhfk_pkg::FRAC_BITS);
    c = rnd_shift(x, 30 - dhfk_pkg::FRAC_BITS);
    if (flip) c = -c;
  endfunction

  function automatic pose_t predict_pose(input longint ang[6]);
    longint t[4][4], h[4][4], p[4][4];
    longint s, c, r, d, one, acc;
    pose_t res;
    one = longint'(1) <<< dhfk_pkg::FRAC_BITS;
    for (int j = 0; j < 6; j++) begin
      sin_cos(ang[j], s, c);
      r = div_near(LINK_R_UM[j] * one, 1000000);
      d = div_near(LINK_D_UM[j] * one, 1000000);
      h[0][0] = c;  h[0][1] = -s * LINK_CA[j]; h[0][2] = s * LINK_SA[j];
      h[0][3] = rnd_shift(r * c, dhfk_pkg::FRAC_BITS);
      h[1][0] = s;  h[1][1] = c * LINK_CA[j];  h[1][2] = -c * LINK_SA[j];
      h[1][3] = rnd_shift(r * s, dhfk_pkg::FRAC_BITS);
      h[2][0] = 0;  h[2][1] = LINK_SA[j] * one; h[2][2] = LINK_CA[j] * one;
      h[2][3] = d;
      h[3][0] = 0;  h[3][1] = 0; h[3][2] = 0; h[3][3] = one;
      if (j == 0) begin
        t = h;
      end else begin
        for (int a = 0; a < 4; a++)
          for (int b = 0; b < 4; b++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) acc += t[a][k] * h[k][b];
            p[a][b] = rnd_shift(acc, dhfk_pkg::FRAC_BITS);
          end
        t = p;
      end
    end
    res.x = dhfk_pkg::OUT_W'(clamp_out(t[0][3]));
    res.y = dhfk_pkg::OUT_W'(clamp_out(t[1][3]));
    res.z = dhfk_pkg::OUT_W'(clamp_out(t[2][3]));
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    checked = 0;
  end

  assign pending = expected_poses.size();

  always @(posedge clk) begin
    longint ang[6];
    pose_t want;
    if (!rst) begin
      if (angle_valid && !angle_stall) begin
        ang[0] = angle_base;
        ang[1] = angle_shoulder;
        ang[2] = angle_elbow;
        ang[3] = angle_wrist_one;
        ang[4] = angle_wrist_two;
        ang[5] = angle_wrist_three;
        expected_poses.push_back(predict_pose(ang));
      end
      if (pos_valid && !pos_stall) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("unexpected transaction", pos_x, 0);
        end else begin
          want = expected_poses.pop_front();
          if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
          if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
          if (pos_z !== want.z) report_mismatch("pos_z", pos_z, want.z);
          checked++;
        end
      end
    end
  end

endmodule

>>> dv/tb_dh_forward_kinematics_6joint_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dh_forward_kinematics_6joint_unit
// drives directed and random joint poses with bursty input and random output
// stalls; the checker predicts each end-effector position and compares
// ----------------------------------------------------------------------------
module tb_dh_forward_kinematics_6joint_unit;

  logic clk, rst;
  logic angle_valid, angle_stall, pos_valid, pos_stall;
  logic signed [dhfk_pkg::ANG_W-1:0] angle_base, angle_shoulder, angle_elbow;
  logic signed [dhfk_pkg::ANG_W-1:0] angle_wrist_one, angle_wrist_two, angle_wrist_three;
  logic signed [dhfk_pkg::OUT_W-1:0] pos_x, pos_y, pos_z;
  int errors, pending, checked;
  int cycles, sent, burst_left;
  bit hold_req, hold_done, stall_free;

  localparam int CYCLE_LIMIT = 300000;

  dh_forward_kinematics_6joint_unit dut (.*);

  dhfk_checker u_checker (.*);

  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // output side stall pattern, with one long hold-off
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    pos_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        pos_stall <= 1;
        repeat (300) @(posedge clk);
        hold_done = 1;
        pos_stall <= 0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(2);
          left = $urandom_range(10, 80);
        end
        left--;
        if (stall_free || mode == 0) pos_stall <= 0;
        else if (mode == 1) pos_stall <= ($urandom_range(99) < 30);
        else pos_stall <= ($urandom_range(99) < 75);
      end
    end
  end

  task automatic send_pose(input logic signed [dhfk_pkg::ANG_W-1:0] a0, a1, a2, a3, a4, a5);
    angle_valid <= 1;
    angle_base <= a0;
    angle_shoulder <= a1;
    angle_elbow <= a2;
    angle_wrist_one <= a3;
    angle_wrist_two <= a4;
    angle_wrist_three <= a5;
    @(posedge clk);
    while (angle_stall) @(posedge clk);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      angle_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  function automatic logic signed [dhfk_pkg::ANG_W-1:0] pick_angle();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return dhfk_pkg::ANG_W'($urandom_range(72000) - 36000);
    if (sel < 80) begin
      return dhfk_pkg::ANG_W'(9000 * ($urandom_range(8) - 4) + $urandom_range(6) - 3);
    end
    return dhfk_pkg::ANG_W'($urandom);
  endfunction

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic signed [dhfk_pkg::ANG_W-1:0] corner[12];
    corner = '{0, 36000, -36000, 9000, -9000, 18000, -18000, 27000, 65535,
               -65536, 9001, -17999};
    rst = 1;
    cycles = 0;
    sent = 0;
    burst_left = 5;
    hold_req = 0;
    hold_done = 0;
    stall_free = 0;
    angle_valid = 0;
    angle_base = 0;
    angle_shoulder = 0;
    angle_elbow = 0;
    angle_wrist_one = 0;
    angle_wrist_two = 0;
    angle_wrist_three = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // home pose, all joints at each corner, then each joint alone at a corner
    for (int i = 0; i < 12; i++)
      send_pose(corner[i], corner[i], corner[i], corner[i], corner[i], corner[i]);
    for (int j = 0; j < 6; j++)
      send_pose(j == 0 ? corner[3] : 0, j == 1 ? corner[5] : 0, j == 2 ? corner[4] : 0,
                j == 3 ? corner[7] : 0, j == 4 ? corner[8] : 0, j == 5 ? corner[9] : 0);
    send_pose(0, -9000, 0, -9000, 0, 0);

    // sender pauses until everything has come back
    angle_valid <= 0;
    @(posedge clk);
    wait_drained();

    hold_req = 1;
    for (int n = 0; n < 800; n++) begin
      if (n == 400) begin
        angle_valid <= 0;
        stall_free = 1;
        @(posedge clk);
        wait_drained();
      end
      if (n == 500) stall_free = 0;
      send_pose(pick_angle(), pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                pick_angle());
    end
    angle_valid <= 0;
    @(posedge clk);
    wait_drained();
    repeat (dhfk_pkg::PIPE_LAT + 10) @(posedge clk);

    $display("sent %0d poses incl. angle corners and wrapped 17-bit angles", sent);
    $display("checked %0d positions under bursty input and output stalls", checked);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
